// ----- src/fse_pkg.sv -----
// fse_pkg: shared constants and controller/datapath interface types
`timescale 1ns / 1ps

package fse_pkg;

  localparam int unsigned DEPTH_DEF      = 1024;
  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned INDEX_W        = 10;
  localparam int unsigned SIZE_W         = 11;
  localparam int unsigned POS_W          = 10;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  typedef struct packed {
    logic wr;         // store the write item
    logic load;       // start a search
    logic fib_step;   // advance the fibonacci triple during setup
    logic probe_rd;   // read the probe entry
    logic probe_upd;  // narrow the range from the probe result
    logic final_rd;   // read the entry just past the offset
    logic final_upd;  // check the final entry
    logic out_load;   // move the result into the output register
  } fse_cmd_t;

  typedef struct packed {
    logic fm_lt_n;
    logic fm_gt_1;
    logic final_ok;
    logic e_lt;
    logic e_gt;
    logic out_free;
  } fse_status_t;

endpackage

// ----- src/fse_ram.sv -----
// fse_ram: generic one-write one-read memory with registered read data
`timescale 1ns / 1ps

module fse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/fse_datapath.sv -----
// fse_datapath: size register, fibonacci registers, element store and result registers
`timescale 1ns / 1ps

module fse_datapath #(
  parameter int unsigned DATA_WIDTH = fse_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fse_pkg::fse_cmd_t                   cmd_i,
  output fse_pkg::fse_status_t                status_o,
  input  logic                                cfg_we_i,
  input  logic [fse_pkg::SIZE_W-1:0]          cfg_wdata_i,
  input  logic [fse_pkg::INDEX_W-1:0]         element_index_i,
  input  logic signed [DATA_WIDTH-1:0]        element_value_i,
  input  logic signed [DATA_WIDTH-1:0]        search_key_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                found_o,
  output logic [fse_pkg::POS_W-1:0]           position_o
);

  localparam int unsigned DEPTH = fse_pkg::DEPTH_DEF;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = (AW + 1 > fse_pkg::SIZE_W) ? AW + 1 : fse_pkg::SIZE_W;
  localparam int unsigned W  = CW + 1;

  logic [fse_pkg::SIZE_W-1:0]   size_q;
  logic signed [DATA_WIDTH-1:0] key_q;
  logic [W-1:0]                 n_q, f2_q, f1_q, fm_q, base_q, pidx_q, where_q;
  logic                         hit_q;
  logic                         out_valid_q, found_q;
  logic [fse_pkg::POS_W-1:0]    pos_q;

  logic [W-1:0]                 size_ext, n_d, idx_ext, probe_sum, probe_idx, n_m1;
  logic                         ram_we, ram_re;
  logic [AW-1:0]                ram_raddr;
  logic signed [DATA_WIDTH-1:0] rd_data;

  assign size_ext  = W'(size_q);
  assign n_d       = (size_ext > W'(DEPTH)) ? W'(DEPTH) : size_ext;
  assign idx_ext   = W'(element_index_i);
  assign ram_we    = cmd_i.wr && (idx_ext < W'(DEPTH));
  assign n_m1      = n_q - W'(1);
  // offset + f2, with base holding offset + 1
  assign probe_sum = base_q + f2_q - W'(1);
  assign probe_idx = (probe_sum > n_m1) ? n_m1 : probe_sum;
  assign ram_re    = cmd_i.probe_rd || cmd_i.final_rd;
  assign ram_raddr = cmd_i.final_rd ? base_q[AW-1:0] : probe_idx[AW-1:0];

  fse_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_ext[AW-1:0]),
    .wdata_i (element_value_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_data)
  );

  assign status_o.fm_lt_n  = fm_q < n_q;
  assign status_o.fm_gt_1  = fm_q > W'(1);
  assign status_o.final_ok = (f1_q != '0) && (base_q < n_q);
  assign status_o.e_lt     = rd_data < key_q;
  assign status_o.e_gt     = rd_data > key_q;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= '0;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.load) begin
        hit_q <= 1'b0;
      end else if (cmd_i.probe_upd && !status_o.e_lt && !status_o.e_gt) begin
        hit_q <= 1'b1;
      end else if (cmd_i.final_upd && !status_o.e_lt && !status_o.e_gt) begin
        hit_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q  <= search_key_i;
      n_q    <= n_d;
      f2_q   <= '0;
      f1_q   <= W'(1);
      fm_q   <= W'(1);
      base_q <= '0;
    end else if (cmd_i.fib_step) begin
      f2_q <= f1_q;
      f1_q <= fm_q;
      fm_q <= f1_q + fm_q;
    end else if (cmd_i.probe_upd) begin
      if (status_o.e_lt) begin
        fm_q   <= f1_q;
        f1_q   <= f2_q;
        f2_q   <= f1_q - f2_q;
        base_q <= pidx_q + W'(1);
      end else if (status_o.e_gt) begin
        fm_q <= f2_q;
        f1_q <= f1_q - f2_q;
        f2_q <= (f2_q << 1) - f1_q;
      end else begin
        where_q <= pidx_q;
      end
    end else if (cmd_i.final_upd) begin
      if (!status_o.e_lt && !status_o.e_gt) begin
        where_q <= base_q;
      end
    end
    if (cmd_i.probe_rd) begin
      pidx_q <= probe_idx;
    end
    if (cmd_i.out_load) begin
      found_q <= hit_q;
      pos_q   <= hit_q ? where_q[fse_pkg::POS_W-1:0] : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign position_o  = pos_q;

endmodule

// ----- src/fse_ctrl.sv -----
// fse_ctrl: search sequencer driving the datapath
`timescale 1ns / 1ps

module fse_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 kind_i,
  input  fse_pkg::fse_status_t status_i,
  output fse_pkg::fse_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_PROBE,
    ST_CMP,
    ST_FINAL_CMP,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (kind_i == fse_pkg::KIND_SEARCH) begin
            cmd_o.load = 1'b1;
            state_d    = ST_SETUP;
          end else begin
            cmd_o.wr = 1'b1;
          end
        end
      end
      ST_SETUP: begin
        if (status_i.fm_lt_n) begin
          cmd_o.fib_step = 1'b1;
        end else begin
          state_d = ST_PROBE;
        end
      end
      ST_PROBE: begin
        priority if (status_i.fm_gt_1) begin
          cmd_o.probe_rd = 1'b1;
          state_d        = ST_CMP;
        end else if (status_i.final_ok) begin
          cmd_o.final_rd = 1'b1;
          state_d        = ST_FINAL_CMP;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_CMP: begin
        cmd_o.probe_upd = 1'b1;
        // equal ends the search at once
        state_d = (status_i.e_lt || status_i.e_gt) ? ST_PROBE : ST_DONE;
      end
      ST_FINAL_CMP: begin
        cmd_o.final_upd = 1'b1;
        state_d         = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- src/fibonacci_search_engine.sv -----
// fibonacci_search_engine: top level of the fibonacci search block
`timescale 1ns / 1ps

// Holds an ascending array of signed elements and answers key lookups by
// fibonacci search over the first size_in_use entries (clamped to the store
// depth of fse_pkg::DEPTH_DEF entries). A write item (kind 0) stores one
// element and gives no result. A search item (kind 1) gives
// one result: found and the matching position, position 0 when not found.
// A search keeps the input stalled through the fibonacci setup steps and the
// probes, the final look just past the offset being skipped when a probe hits
// or the range is empty; each probe is a memory read and then a compare on the
// single read port of the element store. A search also waits while an earlier
// result is still stalled in the output register.
// One item is in work at a time; a finished result waits in an output
// register, so the next item is taken as soon as the result has been moved
// there. size_in_use is written through cfg_we_i; the user must do so only
// while the block is idle, which the block itself does not enforce.
module fibonacci_search_engine #(
  parameter int unsigned DATA_WIDTH = fse_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [fse_pkg::SIZE_W-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         kind_i,
  input  logic [fse_pkg::INDEX_W-1:0]  element_index_i,
  input  logic signed [DATA_WIDTH-1:0] element_value_i,
  input  logic signed [DATA_WIDTH-1:0] search_key_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         found_o,
  output logic [fse_pkg::POS_W-1:0]    position_o
);

  fse_pkg::fse_cmd_t    cmd;
  fse_pkg::fse_status_t status;

  fse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fse_datapath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .element_index_i (element_index_i),
    .element_value_i (element_value_i),
    .search_key_i    (search_key_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .found_o         (found_o),
    .position_o      (position_o)
  );

endmodule

// ----- src/fse_checker.sv -----
// fse_checker: port-level assertions for the fibonacci search block, with bind
`timescale 1ns / 1ps

module fse_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      kind_i,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic                      found_o,
  input logic [fse_pkg::POS_W-1:0] position_o
);

  // a search keeps the input side busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && kind_i == fse_pkg::KIND_SEARCH) |=> in_stall_o)
    else $error("input not stalled after search item");

  // a write item does not stall the input in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && kind_i == fse_pkg::KIND_WRITE) |=> !in_stall_o)
    else $error("input stalled after write item");

  // a miss reports position zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (position_o == '0))
    else $error("nonzero position on miss");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(found_o) && $stable(position_o)))
    else $error("stalled result changed");

endmodule

bind fibonacci_search_engine fse_checker u_fse_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .kind_i      (kind_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .found_o     (found_o),
  .position_o  (position_o)
);

// ----- bench/lookup_checker.sv -----
// lookup_checker: predicts fibonacci search results and compares them with the block output
`timescale 1ns / 1ps

module lookup_checker (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      cfg_we_i,
  input  logic [fse_pkg::SIZE_W-1:0]                cfg_wdata_i,
  input  logic                                      in_valid_i,
  input  logic                                      in_stall_i,
  input  logic                                      kind_i,
  input  logic [fse_pkg::INDEX_W-1:0]               element_index_i,
  input  logic signed [fse_pkg::DATA_WIDTH_DEF-1:0] element_value_i,
  input  logic signed [fse_pkg::DATA_WIDTH_DEF-1:0] search_key_i,
  input  logic                                      out_valid_i,
  input  logic                                      out_stall_i,
  input  logic                                      found_i,
  input  logic [fse_pkg::POS_W-1:0]                 position_i,
  output int unsigned                               mismatches_o,
  output int unsigned                               pending_o
);

  typedef struct packed {
    logic                      found;
    logic [fse_pkg::POS_W-1:0] position;
  } lookup_t;

  logic signed [fse_pkg::DATA_WIDTH_DEF-1:0] elements [fse_pkg::DEPTH_DEF];
  logic [fse_pkg::SIZE_W-1:0]                size_q;
  lookup_t                                   pending_lookups [$];
  int unsigned                               fail_count;

  function automatic logic signed [fse_pkg::DATA_WIDTH_DEF-1:0] element_at(int idx);
    if (idx < 0 || idx >= int'(fse_pkg::DEPTH_DEF)) return '0;
    return elements[idx];
  endfunction

  function automatic lookup_t fib_lookup(logic signed [fse_pkg::DATA_WIDTH_DEF-1:0] key);
    int      n;
    int      fib_lo;
    int      fib_mid;
    int      fib_hi;
    int      base;
    int      probe;
    logic signed [fse_pkg::DATA_WIDTH_DEF-1:0] e;
    lookup_t r;
    n = (size_q > fse_pkg::DEPTH_DEF) ? int'(fse_pkg::DEPTH_DEF) : int'(size_q);
    fib_lo  = 0;
    fib_mid = 1;
    fib_hi  = 1;
    base    = -1;
    r       = '0;
    // smallest fibonacci number not below the size
    while (fib_hi < n) begin
      fib_lo  = fib_mid;
      fib_mid = fib_hi;
      fib_hi  = fib_lo + fib_mid;
    end
    while (fib_hi > 1 && !r.found) begin
      probe = base + fib_lo;
      if (probe > n - 1) probe = n - 1;
      e = element_at(probe);
      if (e < key) begin
        fib_hi  = fib_mid;
        fib_mid = fib_lo;
        fib_lo  = fib_hi - fib_mid;
        base    = probe;
      end else if (e > key) begin
        fib_hi  = fib_lo;
        fib_mid = fib_mid - fib_lo;
        fib_lo  = fib_hi - fib_mid;
      end else begin
        r.found    = 1'b1;
        r.position = probe[fse_pkg::POS_W-1:0];
      end
    end
    // last look just past the offset, skipped for an empty range
    if (!r.found && fib_mid != 0 && base + 1 < n && element_at(base + 1) == key) begin
      r.found    = 1'b1;
      r.position = fse_pkg::POS_W'(base + 1);
    end
    return r;
  endfunction

  task automatic note_fail(string what, lookup_t want, lookup_t got);
    if (fail_count < 10)
      $display("%0t lookup mismatch (%s): expected found=%0d position=%0d, %s",
               $realtime, what, want.found, want.position,
               $sformatf("got found=%0d position=%0d", got.found, got.position));
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    lookup_t want;
    lookup_t got;
    if (!rst_ni) begin
      size_q = '0;
      pending_lookups.delete();
      fail_count = 0;
      mismatches_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) size_q = cfg_wdata_i;
      // a result never belongs to the item taken at the same edge
      if (out_valid_i && !out_stall_i) begin
        got.found    = found_i;
        got.position = position_i;
        if (pending_lookups.size() == 0) begin
          note_fail("no lookup outstanding", '0, got);
        end else begin
          want = pending_lookups.pop_front();
          if (want !== got) note_fail("wrong result", want, got);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (kind_i == fse_pkg::KIND_SEARCH) pending_lookups.push_back(fib_lookup(search_key_i));
        else elements[element_index_i] = element_value_i;
      end
      mismatches_o <= fail_count;
      pending_o <= pending_lookups.size();
    end
  end

endmodule

// ----- bench/testbench.sv -----
// testbench: stimulus, receiver stalls and verdict for the fibonacci search engine
`timescale 1ns / 1ps

module testbench;

  localparam int SETTLE_CYCLES = 8;
  // entries below this are always written; a key at or below entry 0 probes
  // no higher than entry 609 even at full size
  localparam int LOADED = 640;
  localparam logic signed [31:0] MIN_VAL = 32'sh8000_0000;
  localparam logic signed [31:0] MAX_VAL = 32'sh7FFF_FFFF;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_e;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [fse_pkg::SIZE_W-1:0]  cfg_wdata_i;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic                        kind_i;
  logic [fse_pkg::INDEX_W-1:0] element_index_i;
  logic signed [31:0]          element_value_i;
  logic signed [31:0]          search_key_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic                        found_o;
  logic [fse_pkg::POS_W-1:0]   position_o;

  int unsigned         mismatches;
  int unsigned         pending;

  logic signed [31:0]  vals [fse_pkg::DEPTH_DEF];
  int                  items_sent;
  int                  burst_left;
  stall_mode_e         stall_mode;
  int                  mode_left;

  fibonacci_search_engine DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .element_index_i (element_index_i),
    .element_value_i (element_value_i),
    .search_key_i    (search_key_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .found_o         (found_o),
    .position_o      (position_o)
  );

  lookup_checker lookup_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .kind_i          (kind_i),
    .element_index_i (element_index_i),
    .element_value_i (element_value_i),
    .search_key_i    (search_key_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .found_i         (found_o),
    .position_i      (position_o),
    .mismatches_o    (mismatches),
    .pending_o       (pending)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // receiver stalls: modes of random length
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_mode  <= STALL_NONE;
      mode_left   <= 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= stall_mode_e'($urandom_range(0, 2));
        mode_left  <= $urandom_range(50, 400);
      end else begin
        mode_left <= mode_left - 1;
      end
      unique case (stall_mode)
        STALL_NONE:  out_stall_i <= 1'b0;
        STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
        default:     out_stall_i <= ($urandom_range(0, 15) != 0);
      endcase
    end
  end

  // sender gaps between bursts
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_item(input logic kind, input logic [fse_pkg::INDEX_W-1:0] idx,
                           input logic signed [31:0] value, input logic signed [31:0] key);
    in_valid_i      <= 1'b1;
    kind_i          <= kind;
    element_index_i <= idx;
    element_value_i <= value;
    search_key_i    <= key;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    pace();
  endtask

  task automatic write_elem(input int idx, input logic signed [31:0] value);
    vals[idx] = value;
    send_item(fse_pkg::KIND_WRITE, fse_pkg::INDEX_W'(idx), value, $urandom);
  endtask

  task automatic search(input logic signed [31:0] key);
    send_item(fse_pkg::KIND_SEARCH, fse_pkg::INDEX_W'($urandom), $urandom, key);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic set_size(input int n);
    drain();
    // a write item may still be in work after the last result
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= fse_pkg::SIZE_W'(n);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // ascending values over entries 0..n-1, dense runs give duplicates
  task automatic load_sorted(input int n);
    longint span;
    longint cur;
    bit     dense;
    if (n == 0) return;
    span  = 64'hFFFF_FFFF / (n + 1);
    dense = ($urandom_range(0, 3) == 0);
    cur   = longint'(MIN_VAL) + $urandom_range(0, 32'(span));
    for (int i = 0; i < n; i++) begin
      write_elem(i, cur[31:0]);
      cur += dense ? $urandom_range(0, 2) : $urandom_range(1, 32'(span));
    end
  endtask

  function automatic logic signed [31:0] pick_key(input int eff);
    int                 roll;
    logic signed [31:0] v;
    if (eff == 0) return $urandom;
    v    = vals[$urandom_range(0, eff - 1)];
    roll = $urandom_range(0, 9);
    if (roll < 6) return v;
    if (roll == 6) return v + 1;
    if (roll == 7) return v - 1;
    if (roll == 8) return $urandom_range(0, 1) ? MIN_VAL : MAX_VAL;
    return $urandom;
  endfunction

  task automatic run_searches(input int size_cfg, input int count);
    int eff;
    eff = (size_cfg > int'(fse_pkg::DEPTH_DEF)) ? int'(fse_pkg::DEPTH_DEF) : size_cfg;
    set_size(size_cfg);
    if (eff > 0 && eff <= 64 && $urandom_range(0, 1)) load_sorted(eff);
    repeat (count) begin
      // stray writes break the ordering now and then
      if ($urandom_range(0, 9) == 0)
        write_elem(eff > 0 ? $urandom_range(0, eff - 1)
                           : $urandom_range(0, fse_pkg::DEPTH_DEF - 1),
                   $urandom);
      if ($urandom_range(0, 40) == 0) drain();
      search(pick_key(eff));
    end
  endtask

  // sizes around and above the depth, keys that stay in the sorted low part
  task automatic low_key_searches(input int size_cfg);
    set_size(size_cfg);
    search(MIN_VAL);
    search(vals[0]);
  endtask

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int r;
    int sz;
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= '0;
    in_valid_i      <= 1'b0;
    kind_i          <= fse_pkg::KIND_WRITE;
    element_index_i <= '0;
    element_value_i <= '0;
    search_key_i    <= '0;
    items_sent      = 0;
    burst_left      = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty array after reset, nothing is read
    search(0);
    search(MIN_VAL);
    search(MAX_VAL);
    write_elem(0, MIN_VAL);
    write_elem(1, -5);
    write_elem(2, 0);
    write_elem(3, 7);
    write_elem(4, MAX_VAL);
    set_size(1);
    search(MIN_VAL);
    search(3);
    set_size(5);
    for (int i = 0; i < 5; i++) search(vals[i]);
    search(-6);
    search(8);

    // sorted low part, then sizes around and above the depth with low keys
    load_sorted(LOADED);
    low_key_searches(fse_pkg::DEPTH_DEF);
    low_key_searches((1 << fse_pkg::SIZE_W) - 1);
    low_key_searches(fse_pkg::DEPTH_DEF + 1);
    low_key_searches(fse_pkg::DEPTH_DEF - 1);
    run_searches(LOADED, 12);
    run_searches(LOADED - 1, 5);
    run_searches(0, 3);

    while (items_sent < 850) begin
      r = $urandom_range(0, 15);
      if (r < 3) sz = $urandom_range(65, LOADED);
      else sz = $urandom_range(0, 64);
      run_searches(sz, $urandom_range(4, 30));
    end

    drain();
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
